// ===== rtl/float_pcm_frame_ring_writer_core_macros.svh =====
// assertion macros for the frame ring writer rtl
// no dependencies; taken in by fpfrw_ctrl, which carries concurrent checks
`ifndef FLOAT_PCM_FRAME_RING_WRITER_CORE_MACROS_SVH
`define FLOAT_PCM_FRAME_RING_WRITER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FPFRW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FPFRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fpfrw_pkg.sv =====
// shared types, codes and constants of the float to pcm frame ring writer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package fpfrw_pkg;

    // field and bus widths
    localparam int SAMPLE_W    = 32;
    localparam int FRAME_IDX_W = 10;
    localparam int IN_DATA_W   = 64;   // two samples
    localparam int OUT_DATA_W  = 80;   // 74 bits of fields, zero filled to bytes
    localparam int NUM_LANES   = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 2;
    localparam int PROD_W      = 47;   // 24-bit significand times 23-bit scale
    localparam int Q_W         = 25;   // rounded significand incl. carry

    // parameter defaults
    localparam int RING_FRAMES_DEF = 1024;
    localparam int CHANNELS_DEF    = 2;

    // sample format codes
    localparam logic [1:0] FMT_PCM16 = 2'd0;
    localparam logic [1:0] FMT_PCM24 = 2'd1;
    localparam logic [1:0] FMT_FLOAT = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 1'd1;

    // pcm scale factors
    localparam logic [22:0] SCALE_PCM16 = 23'd32767;
    localparam logic [22:0] SCALE_PCM24 = 23'd8388607;

    // float constants
    localparam logic [30:0] FLT_INF_MAG = 31'h7F800000;
    localparam logic [30:0] FLT_ONE_MAG = 31'h3F800000;
    localparam logic [7:0]  FLT_EXP_MAX = 8'hFF;
    localparam logic [8:0]  EXP_BIAS_SH = 9'd150;

    // stage load enables of the lane pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

endpackage

// ===== rtl/fpfrw_lane.sv =====
// one conversion lane: clamp, scale, float rounding, integer rounding
// depends on fpfrw_pkg; instantiated once per channel by the top level
`timescale 1ns / 1ps

module fpfrw_lane (
    input  logic                         i_clk,
    input  logic [1:0]                   i_fmt,
    input  fpfrw_pkg::t_pipe_en          i_en,
    input  logic [fpfrw_pkg::SAMPLE_W-1:0] i_sample,
    output logic [fpfrw_pkg::SAMPLE_W-1:0] o_word
);

    // stage 1 registers
    logic [31:0]                     r1_bits;
    logic [fpfrw_pkg::PROD_W-1:0]    r1_prod;
    logic [7:0]                      r1_ex;
    logic                            r1_kill;
    // stage 2 registers
    logic [31:0]                     r2_bits;
    logic [fpfrw_pkg::Q_W-1:0]       r2_q;
    logic [4:0]                      r2_sh;
    logic                            r2_kill;
    // stage 3 register
    logic [31:0]                     r3_word;

    logic [31:0]                     clamped;
    logic [23:0]                     sig;
    logic [22:0]                     scale;
    logic [fpfrw_pkg::PROD_W-1:0]    prod;
    logic [23:0]                     q24;
    logic                            g2;
    logic                            st2;
    logic [4:0]                      s2;
    logic [8:0]                      sh9;
    logic [fpfrw_pkg::Q_W-1:0]       q25;
    logic [fpfrw_pkg::Q_W-1:0]       q_sh;
    logic [fpfrw_pkg::Q_W-1:0]       lo_mask;
    logic [4:0]                      sh_m1;
    logic                            g3;
    logic                            st3;
    logic [fpfrw_pkg::Q_W-1:0]       mag;
    logic [31:0]                     signed_word;
    logic [31:0]                     n3_word;

    // clamp to [-1, 1], nan kept, then scale the significand
    always_comb begin
        if (i_sample[30:0] > fpfrw_pkg::FLT_INF_MAG) begin
            clamped = i_sample;
        end else if (i_sample[30:0] > fpfrw_pkg::FLT_ONE_MAG) begin
            clamped = {i_sample[31], fpfrw_pkg::FLT_ONE_MAG};
        end else begin
            clamped = i_sample;
        end
        sig   = {1'b1, clamped[22:0]};
        scale = (i_fmt == fpfrw_pkg::FMT_PCM24) ? fpfrw_pkg::SCALE_PCM24
                                                : fpfrw_pkg::SCALE_PCM16;
        prod  = sig * scale;
    end

    // zero, subnormal and nan all encode as zero
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_bits <= clamped;
            r1_prod <= prod;
            r1_ex   <= clamped[30:23];
            r1_kill <= (clamped[30:23] == 8'd0) || (clamped[30:23] == fpfrw_pkg::FLT_EXP_MAX);
        end
    end

    // round the product to 24 significant bits; its length is one of two per format
    always_comb begin
        case ({i_fmt == fpfrw_pkg::FMT_PCM24, r1_prod[46], r1_prod[38]})
            3'b110, 3'b111: begin
                q24 = r1_prod[46:23]; g2 = r1_prod[22]; st2 = |r1_prod[21:0]; s2 = 5'd23;
            end
            3'b100, 3'b101: begin
                q24 = r1_prod[45:22]; g2 = r1_prod[21]; st2 = |r1_prod[20:0]; s2 = 5'd22;
            end
            3'b001, 3'b011: begin
                q24 = r1_prod[38:15]; g2 = r1_prod[14]; st2 = |r1_prod[13:0]; s2 = 5'd15;
            end
            default: begin
                q24 = r1_prod[37:14]; g2 = r1_prod[13]; st2 = |r1_prod[12:0]; s2 = 5'd14;
            end
        endcase
        q25 = {1'b0, q24} + fpfrw_pkg::Q_W'(g2 && (st2 || q24[0]));
        sh9 = fpfrw_pkg::EXP_BIAS_SH - {1'b0, r1_ex} - {4'd0, s2};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_bits <= r1_bits;
            r2_q    <= q25;
            r2_sh   <= sh9[4:0];
            r2_kill <= r1_kill || (sh9 > 9'd24);
        end
    end

    // round to integer, apply sign, fit to the output format
    always_comb begin
        sh_m1   = r2_sh - 5'd1;
        q_sh    = r2_q >> r2_sh;
        g3      = (r2_sh != 5'd0) && r2_q[sh_m1];
        lo_mask = (fpfrw_pkg::Q_W'(1) << sh_m1) - fpfrw_pkg::Q_W'(1);
        st3     = (r2_sh > 5'd1) && (|(r2_q & lo_mask));
        mag     = q_sh + fpfrw_pkg::Q_W'(g3 && (st3 || q_sh[0]));
        if (r2_kill) begin
            signed_word = 32'd0;
        end else if (r2_bits[31]) begin
            signed_word = 32'd0 - {7'd0, mag};
        end else begin
            signed_word = {7'd0, mag};
        end
        case (i_fmt)
            fpfrw_pkg::FMT_PCM16: n3_word = {16'd0, signed_word[15:0]};
            fpfrw_pkg::FMT_PCM24: n3_word = {8'd0, signed_word[23:0]};
            default:              n3_word = r2_bits;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_word <= n3_word;
        end
    end

    assign o_word = r3_word;

endmodule

// ===== rtl/fpfrw_ctrl.sv =====
// pipeline control: stage valids, stall chain, ring write counter, sideband
// depends on fpfrw_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "float_pcm_frame_ring_writer_core_macros.svh"

module fpfrw_ctrl #(
    parameter int RING_FRAMES = fpfrw_pkg::RING_FRAMES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_last,
    input  logic                            i_out_ready,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    output fpfrw_pkg::t_pipe_en             o_en,
    output logic [fpfrw_pkg::FRAME_IDX_W-1:0] o_frame_index,
    output logic                            o_last
);

    localparam int WPOS_W = (RING_FRAMES > 1) ? $clog2(RING_FRAMES) : 1;
    localparam logic [WPOS_W-1:0] WPOS_LAST = WPOS_W'(RING_FRAMES - 1);

    logic              r_v1, r_v2, r_v3;
    logic [WPOS_W-1:0] r_wpos;
    logic [fpfrw_pkg::FRAME_IDX_W-1:0] r1_idx, r2_idx, r3_idx;
    logic              r1_last, r2_last, r3_last;
    logic              en1, en2, en3;
    logic              accept;
    logic [WPOS_W-1:0] n_wpos;

    // a stage loads when it is empty or the next one loads
    assign en3    = !r_v3 || i_out_ready;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign accept = i_in_valid && o_in_ready;
    assign n_wpos = (r_wpos == WPOS_LAST) ? '0 : r_wpos + WPOS_W'(1);

    // stage valids and ring position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_wpos <= '0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (accept) r_wpos <= n_wpos;
        end
    end

    // slot index and end-of-block flag ride along with the item
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_idx  <= fpfrw_pkg::FRAME_IDX_W'(r_wpos);
            r1_last <= i_in_last;
        end
        if (en2) begin
            r2_idx  <= r1_idx;
            r2_last <= r1_last;
        end
        if (en3) begin
            r3_idx  <= r2_idx;
            r3_last <= r2_last;
        end
    end

    assign o_in_ready    = en1 && i_rst_n;
    assign o_out_valid   = r_v3;
    assign o_en          = '{s1: en1, s2: en2, s3: en3};
    assign o_frame_index = r3_idx;
    assign o_last        = r3_last;

    // checks
    `FPFRW_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, accept, r_v1, "accepted item not in stage 1")
    `FPFRW_ASSERT_NEXT(a_wpos_step, i_clk, i_rst_n, accept, r_wpos == (($past(r_wpos) == WPOS_LAST) ? '0 : $past(r_wpos) + WPOS_W'(1)), "ring position did not advance")
    `FPFRW_ASSERT_NEXT(a_wpos_hold, i_clk, i_rst_n, !accept, $stable(r_wpos), "ring position moved without an item")
    `FPFRW_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n, r_v1 && r_v2 && r_v3 && !i_out_ready, !o_in_ready, "item taken into a full pipeline")
    `FPFRW_ASSERT_NEXT(a_stage_shift, i_clk, i_rst_n, r_v2 && en3, r_v3, "stage 2 item lost on transfer")

endmodule

// ===== rtl/float_pcm_frame_ring_writer_core.sv =====
// top level of the float to pcm frame ring writer
// depends on fpfrw_pkg, fpfrw_ctrl and fpfrw_lane
`timescale 1ns / 1ps

// Converts one frame of two single-precision samples per item into 16-bit
// pcm, 24-bit pcm or clamped float words and tags it with its ring slot.
// One frame is taken every clock while the pipeline is not stalled; it passes
// through the multiplier stage, float rounding stage and integer rounding stage,
// the last being the output register. The pipeline only stops when all three
// stages are full and the output is held. Channels at or past the active count
// copy channel 0, or are zero with no channel active.
// The ring slot counts frames modulo RING_FRAMES; its low ten bits are sent.
// Write the configuration only while no frame is in flight.

module float_pcm_frame_ring_writer_core #(
    parameter int RING_FRAMES = fpfrw_pkg::RING_FRAMES_DEF,
    parameter int CHANNELS    = fpfrw_pkg::CHANNELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fpfrw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fpfrw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input frames
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [fpfrw_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,  // sample_0, sample_1
    input  logic                              i_s_axis_tlast,  // last_frame
    // result frames
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [fpfrw_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,  // frame_index, word_0, word_1, zero fill
    output logic                              o_m_axis_tlast   // notify_reader
);

    logic [1:0]                  r_sample_format;
    logic [1:0]                  r_active_channels;
    fpfrw_pkg::t_pipe_en         pipe_en;
    logic [fpfrw_pkg::FRAME_IDX_W-1:0] frame_index;
    logic [1:0]                  ch_eff;
    logic [fpfrw_pkg::SAMPLE_W-1:0] src    [fpfrw_pkg::NUM_LANES];
    logic [fpfrw_pkg::SAMPLE_W-1:0] lane_w [fpfrw_pkg::NUM_LANES];

    // configuration registers
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_format   <= fpfrw_pkg::FMT_FLOAT;
            r_active_channels <= 2'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fpfrw_pkg::REG_SAMPLE_FORMAT:   r_sample_format   <= i_cfg_data;
                fpfrw_pkg::REG_ACTIVE_CHANNELS: r_active_channels <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // active channel count limited to the lanes built
    always_comb begin
        if (32'(r_active_channels) < CHANNELS) begin
            ch_eff = r_active_channels;
        end else begin
            ch_eff = 2'(CHANNELS);
        end
    end

    // handshake and frame bookkeeping
    fpfrw_ctrl #(
        .RING_FRAMES (RING_FRAMES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .i_in_last     (i_s_axis_tlast),
        .i_out_ready   (i_m_axis_tready),
        .o_in_ready    (o_s_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_en          (pipe_en),
        .o_frame_index (frame_index),
        .o_last        (o_m_axis_tlast)
    );

    // per channel source pick and conversion lane
    for (genvar c = 0; c < fpfrw_pkg::NUM_LANES; c++) begin : g_lane
        if (c < CHANNELS) begin : g_on
            always_comb begin
                if (2'(c) < ch_eff) begin
                    src[c] = i_s_axis_tdata[c*fpfrw_pkg::SAMPLE_W +: fpfrw_pkg::SAMPLE_W];
                end else if (ch_eff != 2'd0) begin
                    src[c] = i_s_axis_tdata[fpfrw_pkg::SAMPLE_W-1:0];
                end else begin
                    src[c] = '0;
                end
            end

            fpfrw_lane u_lane (
                .i_clk    (i_clk),
                .i_fmt    (r_sample_format),
                .i_en     (pipe_en),
                .i_sample (src[c]),
                .o_word   (lane_w[c])
            );
        end else begin : g_off
            assign src[c]    = '0;
            assign lane_w[c] = '0;
        end
    end

    // merge slot index and lane words into the result item
    assign o_m_axis_tdata = {6'd0, lane_w[1], lane_w[0], frame_index};

endmodule
